// File: sv/lgm_pkg.sv
// Shared types, constants and helpers of the Lipschitz global minimizer.
`timescale 1ns / 1ps
`default_nettype none
package lgm_pkg;

   localparam int MAX_POINTS = 4096;
   localparam int PTR_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = PTR_W + 1;
   localparam int KEY_W      = 32 + 2 * PTR_W;

   localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

   localparam logic [2:0] CSR_LIP   = 3'd0;
   localparam logic [2:0] CSR_HIL   = 3'd1;
   localparam logic [2:0] CSR_LOWER = 3'd2;
   localparam logic [2:0] CSR_UPPER = 3'd3;
   localparam logic [2:0] CSR_GOAL  = 3'd4;
   localparam logic [2:0] CSR_TGT   = 3'd5;
   localparam logic [2:0] CSR_MAXIT = 3'd6;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_VALUE = 1'b1;

   localparam logic KIND_QUERY = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   localparam logic [4:0] OP_NONE    = 5'd0;
   localparam logic [4:0] OP_START   = 5'd1;
   localparam logic [4:0] OP_LOW     = 5'd2;
   localparam logic [4:0] OP_VAL_UPP = 5'd3;
   localparam logic [4:0] OP_VAL     = 5'd4;
   localparam logic [4:0] OP_HM0     = 5'd5;
   localparam logic [4:0] OP_HM1     = 5'd6;
   localparam logic [4:0] OP_HM2     = 5'd7;
   localparam logic [4:0] OP_HM3     = 5'd8;
   localparam logic [4:0] OP_GAP_B   = 5'd9;
   localparam logic [4:0] OP_GAP_O   = 5'd10;
   localparam logic [4:0] OP_PU_INIT = 5'd11;
   localparam logic [4:0] OP_PU_CHK  = 5'd12;
   localparam logic [4:0] OP_PU_CMP  = 5'd13;
   localparam logic [4:0] OP_POP_INIT = 5'd14;
   localparam logic [4:0] OP_POP_TOP = 5'd15;
   localparam logic [4:0] OP_POP_LAST = 5'd16;
   localparam logic [4:0] OP_PO_CHK  = 5'd17;
   localparam logic [4:0] OP_PO_R2   = 5'd18;
   localparam logic [4:0] OP_PO_CMP  = 5'd19;
   localparam logic [4:0] OP_RDA     = 5'd20;
   localparam logic [4:0] OP_RDB     = 5'd21;
   localparam logic [4:0] OP_RDC     = 5'd22;
   localparam logic [4:0] OP_COMMIT  = 5'd23;
   localparam logic [4:0] OP_EMIT_Q  = 5'd24;
   localparam logic [4:0] OP_EMIT_D  = 5'd25;

   localparam logic [1:0] HSEL_PUSH = 2'd0;
   localparam logic [1:0] HSEL_T    = 2'd1;
   localparam logic [1:0] HSEL_OB   = 2'd2;

   typedef struct packed {
      logic               command;
      logic signed [31:0] func_value;
   } req_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [31:0] query_point;
      logic signed [31:0] best_point;
      logic signed [31:0] best_value;
      logic signed [31:0] reached_precision;
      logic [11:0]        iterations_done;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [4:0] op;
      logic [1:0] hsel;
      logic       second;
      logic       take;
   } cmd_type;

   typedef struct packed {
      logic i_zero;
      logic less;
      logic c_ge;
      logic full;
      logic cont;
      logic ob_ge;
   } stat_type;

   function automatic logic signed [31:0] sat50(input logic signed [49:0] v);
      logic signed [31:0] r;
      if (v > 50'(VAL_MAX)) r = VAL_MAX;
      else if (v < 50'(VAL_MIN)) r = VAL_MIN;
      else r = v[31:0];
      return r;
   endfunction

   function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
      logic signed [31:0] r;
      if (v > 33'(VAL_MAX)) r = VAL_MAX;
      else if (v < 33'(VAL_MIN)) r = VAL_MIN;
      else r = v[31:0];
      return r;
   endfunction

endpackage
`default_nettype wire

// File: sv/lgm_ctrl.sv
// Sequencer of the minimizer: search phase, heap walks and arithmetic steps.
`timescale 1ns / 1ps
`default_nettype none
module lgm_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              req_command,
   output logic                   busy,
   output lgm_pkg::cmd_type       cmd,
   input  wire lgm_pkg::stat_type stat
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_START = 5'd1;
   localparam logic [4:0] S_EMITQ = 5'd2;
   localparam logic [4:0] S_LOW   = 5'd3;
   localparam logic [4:0] S_UPP   = 5'd4;
   localparam logic [4:0] S_SMP   = 5'd5;
   localparam logic [4:0] S_HM0   = 5'd6;
   localparam logic [4:0] S_HM1   = 5'd7;
   localparam logic [4:0] S_HM2   = 5'd8;
   localparam logic [4:0] S_HM3   = 5'd9;
   localparam logic [4:0] S_GAPB  = 5'd10;
   localparam logic [4:0] S_GAPO  = 5'd11;
   localparam logic [4:0] S_PUI   = 5'd12;
   localparam logic [4:0] S_PUC   = 5'd13;
   localparam logic [4:0] S_PUM   = 5'd14;
   localparam logic [4:0] S_NQ    = 5'd15;
   localparam logic [4:0] S_POI   = 5'd16;
   localparam logic [4:0] S_POT   = 5'd17;
   localparam logic [4:0] S_POL   = 5'd18;
   localparam logic [4:0] S_POC   = 5'd19;
   localparam logic [4:0] S_POR   = 5'd20;
   localparam logic [4:0] S_POM   = 5'd21;
   localparam logic [4:0] S_RDA   = 5'd22;
   localparam logic [4:0] S_RDB   = 5'd23;
   localparam logic [4:0] S_RDC   = 5'd24;
   localparam logic [4:0] S_TGT   = 5'd25;
   localparam logic [4:0] S_COMIT = 5'd26;
   localparam logic [4:0] S_FIN   = 5'd27;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_LOWER  = 2'd1;
   localparam logic [1:0] PH_UPPER  = 2'd2;
   localparam logic [1:0] PH_SAMPLE = 2'd3;

   logic [4:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] hsel_ff, hsel_in;
   logic       second_ff, second_in;
   logic [4:0] push_done;

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      if (phase_ff == PH_SAMPLE && !second_ff) push_done = S_PUI;
      else push_done = S_NQ;
   end

   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      hsel_in   = hsel_ff;
      second_in = second_ff;
      cmd       = '{op: lgm_pkg::OP_NONE, hsel: hsel_ff, second: second_ff, take: 1'b0};
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.take = 1'b1;
               if (req_command == lgm_pkg::CMD_START) state_in = S_START;
               else begin
                  case (phase_ff)
                     PH_LOWER:  state_in = S_LOW;
                     PH_UPPER:  state_in = S_UPP;
                     PH_SAMPLE: state_in = S_SMP;
                     default:   state_in = S_IDLE;
                  endcase
               end
            end
         end
         S_START: begin
            cmd.op   = lgm_pkg::OP_START;
            phase_in = PH_LOWER;
            state_in = S_EMITQ;
         end
         S_EMITQ: begin
            cmd.op   = lgm_pkg::OP_EMIT_Q;
            state_in = S_IDLE;
         end
         S_LOW: begin
            cmd.op   = lgm_pkg::OP_LOW;
            phase_in = PH_UPPER;
            state_in = S_EMITQ;
         end
         S_UPP: begin
            cmd.op    = lgm_pkg::OP_VAL_UPP;
            hsel_in   = lgm_pkg::HSEL_PUSH;
            second_in = 1'b0;
            state_in  = S_HM0;
         end
         S_SMP: begin
            cmd.op    = lgm_pkg::OP_VAL;
            hsel_in   = lgm_pkg::HSEL_PUSH;
            second_in = 1'b0;
            state_in  = S_HM0;
         end
         S_HM0: begin
            cmd.op   = lgm_pkg::OP_HM0;
            state_in = S_HM1;
         end
         S_HM1: begin
            cmd.op   = lgm_pkg::OP_HM1;
            state_in = S_HM2;
         end
         S_HM2: begin
            cmd.op   = lgm_pkg::OP_HM2;
            state_in = S_HM3;
         end
         S_HM3: begin
            cmd.op = lgm_pkg::OP_HM3;
            case (hsel_ff)
               lgm_pkg::HSEL_PUSH: state_in = (phase_ff == PH_UPPER) ? S_GAPB : S_GAPO;
               lgm_pkg::HSEL_T: begin
                  hsel_in  = lgm_pkg::HSEL_OB;
                  state_in = S_HM0;
               end
               default: state_in = S_TGT;
            endcase
         end
         S_GAPB: begin
            cmd.op   = lgm_pkg::OP_GAP_B;
            state_in = S_PUI;
         end
         S_GAPO: begin
            cmd.op   = lgm_pkg::OP_GAP_O;
            state_in = S_PUI;
         end
         S_PUI: begin
            cmd.op = lgm_pkg::OP_PU_INIT;
            if (stat.full) begin
               second_in = 1'b1;
               state_in  = push_done;
            end else state_in = S_PUC;
         end
         S_PUC: begin
            cmd.op = lgm_pkg::OP_PU_CHK;
            if (stat.i_zero) begin
               second_in = 1'b1;
               state_in  = push_done;
            end else state_in = S_PUM;
         end
         S_PUM: begin
            cmd.op = lgm_pkg::OP_PU_CMP;
            if (stat.less) state_in = S_PUC;
            else begin
               second_in = 1'b1;
               state_in  = push_done;
            end
         end
         S_NQ: begin
            state_in = stat.cont ? S_POI : S_FIN;
         end
         S_POI: begin
            cmd.op   = lgm_pkg::OP_POP_INIT;
            state_in = S_POT;
         end
         S_POT: begin
            cmd.op   = lgm_pkg::OP_POP_TOP;
            state_in = S_POL;
         end
         S_POL: begin
            cmd.op   = lgm_pkg::OP_POP_LAST;
            state_in = S_POC;
         end
         S_POC: begin
            cmd.op   = lgm_pkg::OP_PO_CHK;
            state_in = stat.c_ge ? S_RDA : S_POR;
         end
         S_POR: begin
            cmd.op   = lgm_pkg::OP_PO_R2;
            state_in = S_POM;
         end
         S_POM: begin
            cmd.op   = lgm_pkg::OP_PO_CMP;
            state_in = stat.less ? S_POC : S_RDA;
         end
         S_RDA: begin
            cmd.op   = lgm_pkg::OP_RDA;
            state_in = S_RDB;
         end
         S_RDB: begin
            cmd.op   = lgm_pkg::OP_RDB;
            state_in = S_RDC;
         end
         S_RDC: begin
            cmd.op   = lgm_pkg::OP_RDC;
            hsel_in  = lgm_pkg::HSEL_T;
            state_in = S_HM0;
         end
         S_TGT: begin
            state_in = stat.ob_ge ? S_FIN : S_COMIT;
         end
         S_COMIT: begin
            cmd.op   = lgm_pkg::OP_COMMIT;
            phase_in = PH_SAMPLE;
            state_in = S_EMITQ;
         end
         S_FIN: begin
            cmd.op   = lgm_pkg::OP_EMIT_D;
            phase_in = PH_IDLE;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         phase_ff  <= PH_IDLE;
         hsel_ff   <= lgm_pkg::HSEL_PUSH;
         second_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         phase_ff  <= phase_in;
         hsel_ff   <= hsel_in;
         second_ff <= second_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/lgm_dp.sv
// Datapath of the minimizer: registers, sample and heap memories, bound arithmetic.
`timescale 1ns / 1ps
`default_nettype none
module lgm_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lgm_pkg::req_type   req_data,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_index,
   input  wire logic [31:0]        csr_wdata,
   input  wire lgm_pkg::cmd_type   cmd,
   output lgm_pkg::stat_type       stat,
   output logic                    rsp_strobe,
   output lgm_pkg::rsp_type        rsp_data
);

   localparam int PW = lgm_pkg::PTR_W;
   localparam int CW = lgm_pkg::CNT_W;
   localparam int KW = lgm_pkg::KEY_W;
   localparam int MAX_IDX = lgm_pkg::MAX_POINTS - 1;

   logic [30:0] lip_ff, lip_in, hil_ff, hil_in, goal_ff, goal_in;
   logic signed [31:0] lo_ff, lo_in, up_ff, up_in, tgt_ff, tgt_in;
   logic [11:0] maxit_ff, maxit_in;

   logic signed [31:0] fin_ff, fin_in, xq_ff, xq_in, xl_ff, xl_in, fl_ff, fl_in;
   logic signed [31:0] bestx_ff, bestx_in, bestf_ff, bestf_in, gap_ff, gap_in;
   logic signed [31:0] ob_ff, ob_in, bnd_ff, bnd_in, pt_ff, pt_in;
   logic signed [31:0] xa_ff, xa_in, fa_ff, fa_in, xb_ff, xb_in, fb_ff, fb_in;
   logic [11:0] iter_ff, iter_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] ol_ff, ol_in, or_ff, or_in, ta_ff, ta_in, tb_ff, tb_in;
   logic [PW-1:0] i_ff, i_in, c_ff, c_in;
   logic [KW-1:0] e_ff, e_in, ch_ff, ch_in;
   logic signed [32:0] hs_ff, hs_in, hd_ff, hd_in;
   logic [30:0] hk_ff, hk_in;
   logic signed [49:0] hlo_ff, hlo_in;
   logic signed [48:0] hhi_ff, hhi_in;
   logic signed [65:0] hacc_ff, hacc_in;
   lgm_pkg::rsp_type rsp_ff, rsp_in;
   logic rspv_ff, rspv_in;

   logic [31:0]   point_mem [MAX_IDX:0];
   logic [31:0]   value_mem [MAX_IDX:0];
   logic [KW-1:0] heap_mem  [MAX_IDX:0];

   logic          pm_we, vm_we, hm_we;
   logic [PW-1:0] pm_wa, vm_wa, hm_wa, pm_ra, vm_ra, hm_ra;
   logic [31:0]   pm_wd, vm_wd;
   logic [KW-1:0] hm_wd;
   logic [31:0]   prd_ff, vrd_ff;
   logic [KW-1:0] hrd_ff;

   logic signed [65:0] hsum;
   logic signed [31:0] hres;
   logic [PW:0]        cw;
   logic               c_ge;
   logic               two;
   logic               pick;
   logic [KW-1:0]      cand;
   logic [PW-1:0]      cidx;
   logic [PW-1:0]      parent;
   logic [KW-1:0]      new_key;

   assign hsum   = hacc_ff + (66'(hhi_ff) <<< 16);
   assign hres   = lgm_pkg::sat50(hsum[65:16]);
   assign cw     = {i_ff, 1'b1};
   assign c_ge   = {1'b0, cw} >= {1'b0, cnt_ff};
   assign two    = ({1'b0, c_ff} + 1'b1) < cnt_ff;
   assign pick   = two && (hrd_ff < ch_ff);
   assign cand   = pick ? hrd_ff : ch_ff;
   assign cidx   = pick ? c_ff + 1'b1 : c_ff;
   assign parent = (i_ff - 1'b1) >> 1;
   assign new_key = cmd.second ? {~bnd_ff[31], bnd_ff[30:0], iter_ff[PW-1:0], or_ff}
                               : {~bnd_ff[31], bnd_ff[30:0], ol_ff, iter_ff[PW-1:0]};

   always_comb begin
      stat.i_zero = (i_ff == '0);
      stat.c_ge   = c_ge;
      stat.full   = cnt_ff[CW-1];
      stat.cont   = (iter_ff < maxit_ff) && (gap_ff > $signed({1'b0, goal_ff}))
                    && (cnt_ff != '0);
      stat.ob_ge  = (ob_ff >= tgt_ff);
      if (cmd.op == lgm_pkg::OP_PU_CMP) stat.less = (e_ff < hrd_ff);
      else stat.less = (cand < e_ff);
   end

   always_comb begin
      lip_in = lip_ff; hil_in = hil_ff; goal_in = goal_ff;
      lo_in = lo_ff; up_in = up_ff; tgt_in = tgt_ff; maxit_in = maxit_ff;
      fin_in = fin_ff; xq_in = xq_ff; xl_in = xl_ff; fl_in = fl_ff;
      bestx_in = bestx_ff; bestf_in = bestf_ff; gap_in = gap_ff;
      ob_in = ob_ff; bnd_in = bnd_ff; pt_in = pt_ff;
      xa_in = xa_ff; fa_in = fa_ff; xb_in = xb_ff; fb_in = fb_ff;
      iter_in = iter_ff; cnt_in = cnt_ff; ol_in = ol_ff; or_in = or_ff;
      ta_in = ta_ff; tb_in = tb_ff; i_in = i_ff; c_in = c_ff;
      e_in = e_ff; ch_in = ch_ff;
      hs_in = hs_ff; hd_in = hd_ff; hk_in = hk_ff;
      hlo_in = hlo_ff; hhi_in = hhi_ff; hacc_in = hacc_ff;
      rsp_in = rsp_ff; rspv_in = 1'b0;
      pm_we = 1'b0; pm_wa = '0; pm_wd = '0; pm_ra = '0;
      vm_we = 1'b0; vm_wa = '0; vm_wd = '0; vm_ra = '0;
      hm_we = 1'b0; hm_wa = '0; hm_wd = '0; hm_ra = '0;

      if (csr_we) begin
         case (csr_index)
            lgm_pkg::CSR_LIP:   lip_in   = csr_wdata[30:0];
            lgm_pkg::CSR_HIL:   hil_in   = csr_wdata[30:0];
            lgm_pkg::CSR_LOWER: lo_in    = csr_wdata;
            lgm_pkg::CSR_UPPER: up_in    = csr_wdata;
            lgm_pkg::CSR_GOAL:  goal_in  = csr_wdata[30:0];
            lgm_pkg::CSR_TGT:   tgt_in   = csr_wdata;
            lgm_pkg::CSR_MAXIT: maxit_in = csr_wdata[11:0];
            default: ;
         endcase
      end

      if (cmd.take) fin_in = req_data.func_value;

      case (cmd.op)
         lgm_pkg::OP_START: begin
            cnt_in = '0; iter_in = '0;
            bestx_in = '0; bestf_in = lgm_pkg::VAL_MAX; gap_in = lgm_pkg::VAL_MAX;
            ol_in = '0; or_in = '0; ob_in = '0;
            xq_in = lo_ff;
            pm_we = 1'b1; pm_wa = '0; pm_wd = lo_ff;
         end
         lgm_pkg::OP_LOW: begin
            vm_we = 1'b1; vm_wa = '0; vm_wd = fin_ff;
            if (bestf_ff > fin_ff) begin
               bestf_in = fin_ff; bestx_in = xq_ff;
            end
            xl_in = xq_ff; fl_in = fin_ff;
            pm_we = 1'b1; pm_wa = PW'(1); pm_wd = up_ff;
            xq_in = up_ff;
         end
         lgm_pkg::OP_VAL_UPP, lgm_pkg::OP_VAL: begin
            vm_we = 1'b1; vm_wd = fin_ff;
            if (cmd.op == lgm_pkg::OP_VAL_UPP) begin
               vm_wa = PW'(1); iter_in = 12'd1;
            end else vm_wa = iter_ff[PW-1:0];
            if (bestf_ff > fin_ff) begin
               bestf_in = fin_ff; bestx_in = xq_ff;
            end
         end
         lgm_pkg::OP_HM0: begin
            case (cmd.hsel)
               lgm_pkg::HSEL_PUSH: begin
                  hs_in = 33'(fl_ff) + 33'(fin_ff);
                  hd_in = 33'(xl_ff) - 33'(xq_ff);
                  hk_in = lip_ff;
               end
               lgm_pkg::HSEL_T: begin
                  hs_in = 33'(xa_ff) + 33'(xb_ff);
                  hd_in = 33'(fa_ff) - 33'(fb_ff);
                  hk_in = hil_ff;
               end
               default: begin
                  hs_in = 33'(fa_ff) + 33'(fb_ff);
                  hd_in = 33'(xa_ff) - 33'(xb_ff);
                  hk_in = lip_ff;
               end
            endcase
         end
         lgm_pkg::OP_HM1: hlo_in = 50'(hd_ff) * 50'($signed({1'b0, hk_ff[15:0]}));
         lgm_pkg::OP_HM2: begin
            hacc_in = 66'(hlo_ff) + (66'(hs_ff) <<< 15);
            hhi_in  = 49'(hd_ff) * 49'($signed({1'b0, hk_ff[30:16]}));
         end
         lgm_pkg::OP_HM3: begin
            case (cmd.hsel)
               lgm_pkg::HSEL_PUSH: bnd_in = hres;
               lgm_pkg::HSEL_T:    pt_in  = hres;
               default:            ob_in  = hres;
            endcase
         end
         lgm_pkg::OP_GAP_B: gap_in = lgm_pkg::sat33(33'(bestf_ff) - 33'(bnd_ff));
         lgm_pkg::OP_GAP_O: gap_in = lgm_pkg::sat33(33'(bestf_ff) - 33'(ob_ff));
         lgm_pkg::OP_PU_INIT: begin
            if (!cnt_ff[CW-1]) begin
               e_in   = new_key;
               i_in   = cnt_ff[PW-1:0];
               cnt_in = cnt_ff + 1'b1;
            end
         end
         lgm_pkg::OP_PU_CHK: begin
            if (i_ff == '0) begin
               hm_we = 1'b1; hm_wa = '0; hm_wd = e_ff;
            end else begin
               hm_ra = parent; c_in = parent;
            end
         end
         lgm_pkg::OP_PU_CMP: begin
            hm_we = 1'b1; hm_wa = i_ff;
            if (e_ff < hrd_ff) begin
               hm_wd = hrd_ff; i_in = c_ff;
            end else hm_wd = e_ff;
         end
         lgm_pkg::OP_POP_INIT: begin
            iter_in = iter_ff + 1'b1;
            cnt_in  = cnt_ff - 1'b1;
            hm_ra   = '0;
         end
         lgm_pkg::OP_POP_TOP: begin
            ta_in = hrd_ff[2*PW-1:PW];
            tb_in = hrd_ff[PW-1:0];
            hm_ra = cnt_ff[PW-1:0];
         end
         lgm_pkg::OP_POP_LAST: begin
            e_in = hrd_ff; i_in = '0;
         end
         lgm_pkg::OP_PO_CHK: begin
            if (c_ge) begin
               hm_we = 1'b1; hm_wa = i_ff; hm_wd = e_ff;
            end else begin
               hm_ra = cw[PW-1:0]; c_in = cw[PW-1:0];
            end
         end
         lgm_pkg::OP_PO_R2: begin
            ch_in = hrd_ff;
            hm_ra = c_ff + 1'b1;
         end
         lgm_pkg::OP_PO_CMP: begin
            hm_we = 1'b1; hm_wa = i_ff;
            if (cand < e_ff) begin
               hm_wd = cand; i_in = cidx;
            end else hm_wd = e_ff;
         end
         lgm_pkg::OP_RDA: begin
            pm_ra = ta_ff; vm_ra = ta_ff;
         end
         lgm_pkg::OP_RDB: begin
            xa_in = prd_ff; fa_in = vrd_ff;
            pm_ra = tb_ff; vm_ra = tb_ff;
         end
         lgm_pkg::OP_RDC: begin
            xb_in = prd_ff; fb_in = vrd_ff;
         end
         lgm_pkg::OP_COMMIT: begin
            ol_in = ta_ff; or_in = tb_ff;
            pm_we = 1'b1; pm_wa = iter_ff[PW-1:0]; pm_wd = pt_ff;
            xq_in = pt_ff; xl_in = xa_ff; fl_in = fa_ff;
         end
         lgm_pkg::OP_EMIT_Q, lgm_pkg::OP_EMIT_D: begin
            rspv_in = 1'b1;
            rsp_in.result_kind       = (cmd.op == lgm_pkg::OP_EMIT_D) ?
                                       lgm_pkg::KIND_DONE : lgm_pkg::KIND_QUERY;
            rsp_in.query_point       = (cmd.op == lgm_pkg::OP_EMIT_D) ? '0 : xq_ff;
            rsp_in.best_point        = bestx_ff;
            rsp_in.best_value        = bestf_ff;
            rsp_in.reached_precision = gap_ff;
            rsp_in.iterations_done   = iter_ff;
            rsp_in.status            = gap_ff[31];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (pm_we) point_mem[pm_wa] <= pm_wd;
      prd_ff <= point_mem[pm_ra];
   end

   always_ff @(posedge clock) begin
      if (vm_we) value_mem[vm_wa] <= vm_wd;
      vrd_ff <= value_mem[vm_ra];
   end

   always_ff @(posedge clock) begin
      if (hm_we) heap_mem[hm_wa] <= hm_wd;
      hrd_ff <= heap_mem[hm_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lip_ff <= 31'd65536; hil_ff <= 31'd32768; goal_ff <= 31'd66;
         lo_ff <= '0; up_ff <= 32'sd65536; tgt_ff <= lgm_pkg::VAL_MAX;
         maxit_ff <= 12'd4095;
         bestx_ff <= '0; bestf_ff <= lgm_pkg::VAL_MAX; gap_ff <= lgm_pkg::VAL_MAX;
         iter_ff <= '0; cnt_ff <= '0; ol_ff <= '0; or_ff <= '0; ob_ff <= '0;
         rspv_ff <= 1'b0;
      end else begin
         lip_ff <= lip_in; hil_ff <= hil_in; goal_ff <= goal_in;
         lo_ff <= lo_in; up_ff <= up_in; tgt_ff <= tgt_in; maxit_ff <= maxit_in;
         bestx_ff <= bestx_in; bestf_ff <= bestf_in; gap_ff <= gap_in;
         iter_ff <= iter_in; cnt_ff <= cnt_in; ol_ff <= ol_in; or_ff <= or_in;
         ob_ff <= ob_in;
         rspv_ff <= rspv_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff <= fin_in; xq_ff <= xq_in; xl_ff <= xl_in; fl_ff <= fl_in;
      bnd_ff <= bnd_in; pt_ff <= pt_in;
      xa_ff <= xa_in; fa_ff <= fa_in; xb_ff <= xb_in; fb_ff <= fb_in;
      ta_ff <= ta_in; tb_ff <= tb_in; i_ff <= i_in; c_ff <= c_in;
      e_ff <= e_in; ch_ff <= ch_in;
      hs_ff <= hs_in; hd_ff <= hd_in; hk_ff <= hk_in;
      hlo_ff <= hlo_in; hhi_ff <= hhi_in; hacc_ff <= hacc_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rspv_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire

// File: sv/lipschitz_global_minimizer.sv
// Top level of the Lipschitz global minimizer: sequencer plus datapath.
// Start word: answered with a query for the lower end; first value: the upper end.
// Later values: the sample is stored, its bound is computed and up to two heap pushes
// follow; unless the search then ends, the best span is popped and the next query formed.
// One word at a time; busy is high until the result strobe. Results cannot be stalled.
// Reset is synchronous: registers to defaults, search idle; stores are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module lipschitz_global_minimizer (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire lgm_pkg::req_type req_data,
   output logic                  rsp_strobe,
   output lgm_pkg::rsp_type      rsp_data,
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);

   lgm_pkg::cmd_type  cmd;
   lgm_pkg::stat_type stat;

   lgm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_data.command),
      .busy        (busy),
      .cmd         (cmd),
      .stat        (stat)
   );

   lgm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// File: verif/tb_lipschitz_global_minimizer.sv
// Self-checking testbench of the Lipschitz global minimizer with its own search predictor.
`timescale 1ns / 1ps
module tb_lipschitz_global_minimizer;

   localparam int DRAIN_CYCLES = 400;
   localparam int STALL_LIMIT  = 20000;
   localparam int NPTS         = lgm_pkg::MAX_POINTS;

   typedef struct {
      longint bound;
      int     left;
      int     right;
   } span_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   lgm_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   lgm_pkg::rsp_type rsp_data;
   logic             csr_we = 1'b0;
   logic [2:0]       csr_index = lgm_pkg::CSR_LIP;
   logic [31:0]      csr_wdata = '0;

   lipschitz_global_minimizer u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_strobe(rsp_strobe), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   lgm_pkg::req_type pending_words[$];
   lgm_pkg::rsp_type expected_rsp[$];
   int  errors = 0;
   int  n_words = 0;
   int  n_queries = 0;
   int  n_done = 0;
   int  n_phases = 0;
   int  gap_left = 0;
   int  stall = 0;
   bit  taken = 1'b0;

   // search predictor state
   longint   m_lip, m_hil, m_lower, m_upper, m_goal, m_target, m_maxit;
   longint   pts [NPTS];
   longint   vals[NPTS];
   span_type heap[NPTS];
   int       heap_n, iter_n, open_l, open_r;
   int       phase_s;
   longint   best_x, best_f, gap_v, open_b;

   function automatic longint clamp32(input longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   function automatic longint mix_half(input longint s, input longint d, input longint k);
      longint r, q, rem;
      r   = d * k;
      q   = r >>> 16;
      rem = r & 64'hFFFF;
      return clamp32(q + ((s * 32768 + rem) >>> 16));
   endfunction

   function automatic bit span_lt(input span_type a, input span_type b);
      if (a.bound != b.bound) return a.bound < b.bound;
      if (a.left != b.left) return a.left < b.left;
      return a.right < b.right;
   endfunction

   task automatic heap_insert(input longint bnd, input int l, input int r);
      span_type e;
      int       i, p;
      if (heap_n >= NPTS) return;
      e.bound = bnd; e.left = l; e.right = r;
      i = heap_n;
      heap_n++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (!span_lt(e, heap[p])) break;
         heap[i] = heap[p];
         i = p;
      end
      heap[i] = e;
   endtask

   task automatic heap_take(output span_type top);
      span_type last;
      int       i, c;
      top = heap[0];
      i = 0;
      heap_n--;
      last = heap[heap_n];
      forever begin
         c = 2 * i + 1;
         if (c >= heap_n) break;
         if (c + 1 < heap_n && span_lt(heap[c + 1], heap[c])) c++;
         if (!span_lt(heap[c], last)) break;
         heap[i] = heap[c];
         i = c;
      end
      heap[i] = last;
   endtask

   function automatic lgm_pkg::rsp_type make_rsp(input logic kind, input longint q);
      lgm_pkg::rsp_type r;
      r.result_kind       = kind;
      r.query_point       = q[31:0];
      r.best_point        = best_x[31:0];
      r.best_value        = best_f[31:0];
      r.reached_precision = gap_v[31:0];
      r.iterations_done   = iter_n[11:0];
      r.status            = gap_v < 0;
      return r;
   endfunction

   task automatic take_sample(input longint x, input longint f);
      if (best_f > f) begin
         best_f = f;
         best_x = x;
      end
   endtask

   task automatic next_point(output lgm_pkg::rsp_type r);
      longint   limit, t;
      span_type s;
      limit = m_maxit < NPTS - 1 ? m_maxit : NPTS - 1;
      if (!(iter_n < limit && gap_v > m_goal) || heap_n == 0) begin
         phase_s = 0;
         r = make_rsp(lgm_pkg::KIND_DONE, 0);
         return;
      end
      iter_n++;
      heap_take(s);
      t = mix_half(pts[s.left] + pts[s.right], vals[s.left] - vals[s.right], m_hil);
      open_b = mix_half(vals[s.left] + vals[s.right], pts[s.left] - pts[s.right], m_lip);
      if (open_b >= m_target) begin
         phase_s = 0;
         r = make_rsp(lgm_pkg::KIND_DONE, 0);
         return;
      end
      open_l = s.left;
      open_r = s.right;
      pts[iter_n % NPTS] = t;
      phase_s = 3;
      r = make_rsp(lgm_pkg::KIND_QUERY, t);
   endtask

   task automatic predict_word(input lgm_pkg::req_type w, output bit has,
                               output lgm_pkg::rsp_type r);
      longint f, b;
      int     k;
      f = longint'(w.func_value);
      has = 1'b1;
      r = '0;
      if (w.command == lgm_pkg::CMD_START) begin
         heap_n = 0; iter_n = 0;
         best_x = 0; best_f = 64'sh7FFF_FFFF; gap_v = 64'sh7FFF_FFFF;
         open_l = 0; open_r = 0; open_b = 0;
         pts[0] = m_lower;
         phase_s = 1;
         r = make_rsp(lgm_pkg::KIND_QUERY, m_lower);
      end else if (phase_s == 1) begin
         vals[0] = f;
         take_sample(pts[0], f);
         pts[1] = m_upper;
         phase_s = 2;
         r = make_rsp(lgm_pkg::KIND_QUERY, m_upper);
      end else if (phase_s == 2) begin
         vals[1] = f;
         take_sample(pts[1], f);
         b = mix_half(vals[0] + vals[1], pts[0] - pts[1], m_lip);
         gap_v = clamp32(best_f - b);
         heap_insert(b, 0, 1);
         iter_n = 1;
         next_point(r);
      end else if (phase_s == 3) begin
         k = iter_n % NPTS;
         vals[k] = f;
         take_sample(pts[k], f);
         gap_v = clamp32(best_f - open_b);
         b = mix_half(vals[open_l] + f, pts[open_l] - pts[k], m_lip);
         heap_insert(b, open_l, k);
         heap_insert(b, k, open_r);
         next_point(r);
      end else begin
         has = 1'b0;
      end
   endtask

   task automatic check_field(input string name, input longint e, input longint a);
      if (e != a) begin
         $display("%0t mismatch %s expected %0h actual %0h", $time, name, e, a);
         errors++;
      end
   endtask

   // monitor: check results, then predict accepted words
   always @(posedge clock) begin
      bit               has;
      lgm_pkg::rsp_type r, e;
      if (reset) begin
         m_lip = 65536; m_hil = 32768; m_lower = 0; m_upper = 65536;
         m_goal = 66; m_target = 64'sh7FFF_FFFF; m_maxit = 4095;
         heap_n = 0; iter_n = 0; phase_s = 0; open_l = 0; open_r = 0; open_b = 0;
         best_x = 0; best_f = 64'sh7FFF_FFFF; gap_v = 64'sh7FFF_FFFF;
         taken <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               lgm_pkg::CSR_LIP:   m_lip    = csr_wdata[30:0];
               lgm_pkg::CSR_HIL:   m_hil    = csr_wdata[30:0];
               lgm_pkg::CSR_LOWER: m_lower  = longint'($signed(csr_wdata));
               lgm_pkg::CSR_UPPER: m_upper  = longint'($signed(csr_wdata));
               lgm_pkg::CSR_GOAL:  m_goal   = csr_wdata[30:0];
               lgm_pkg::CSR_TGT:   m_target = longint'($signed(csr_wdata));
               lgm_pkg::CSR_MAXIT: m_maxit  = csr_wdata[11:0];
               default: ;
            endcase
         end
         if (rsp_strobe) begin
            r = rsp_data;
            if (expected_rsp.size() == 0) begin
               $display("%0t unexpected result expected none actual %0h", $time, r);
               errors++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("result_kind", e.result_kind, r.result_kind);
               check_field("query_point", e.query_point, r.query_point);
               check_field("best_point", e.best_point, r.best_point);
               check_field("best_value", e.best_value, r.best_value);
               check_field("reached_precision", e.reached_precision, r.reached_precision);
               check_field("iterations_done", e.iterations_done, r.iterations_done);
               check_field("status", e.status, r.status);
            end
            if (r.result_kind == lgm_pkg::KIND_DONE) n_done++;
            else n_queries++;
         end
         taken <= start && !busy;
         if (start && !busy) begin
            n_words++;
            predict_word(req_data, has, r);
            if (has) expected_rsp = {expected_rsp, r};
         end
         stall = (rsp_strobe || (start && !busy)) ? 0 : stall + 1;
         if (stall >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // driver: hold start until the word is taken, then idle or advance
   always @(negedge clock) begin
      if (!reset && !(start && !taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            start    <= 1'b0;
         end else if (pending_words.size() != 0) begin
            req_data <= pending_words.pop_front();
            start    <= 1'b1;
            case ($urandom_range(0, 19))
               0:       gap_left <= $urandom_range(20, 60);
               1, 2, 3, 4, 5: gap_left <= $urandom_range(1, 4);
               default: gap_left <= 0;
            endcase
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [31:0] v);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic add_word(input logic cmd, input logic [31:0] v);
      lgm_pkg::req_type w;
      w.command    = cmd;
      w.func_value = v;
      pending_words = {pending_words, w};
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 9))
         0:       return $urandom();
         1:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   task automatic add_search(input int n);
      add_word(lgm_pkg::CMD_START, $urandom());
      repeat (n) add_word(lgm_pkg::CMD_VALUE, rand_value());
   endtask

   task automatic drain();
      do begin
         @(posedge clock);
         #2;
      end while (pending_words.size() != 0 || start || expected_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      n_phases++;
   endtask

   function automatic logic [31:0] rand_reg(input logic [31:0] lo, input logic [31:0] hi,
                                            input logic [31:0] typ);
      case ($urandom_range(0, 5))
         0:       return lo;
         1:       return hi;
         2:       return $urandom();
         default: return typ;
      endcase
   endfunction

   initial begin
      int budget;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // defaults: value while idle, full search steps, restart mid-search
      add_word(lgm_pkg::CMD_VALUE, 32'h1234_5678);
      add_word(lgm_pkg::CMD_START, 32'h0);
      add_word(lgm_pkg::CMD_VALUE, 32'h7FFF_FFFF);
      add_word(lgm_pkg::CMD_VALUE, 32'h8000_0000);
      add_word(lgm_pkg::CMD_VALUE, 32'h0000_0000);
      add_word(lgm_pkg::CMD_VALUE, 32'hFFFF_FFFF);
      add_search(4);
      drain();

      // small constant: negative precision, iteration limit zero
      csr_write(lgm_pkg::CSR_LIP, 32'h0000_0001);
      csr_write(lgm_pkg::CSR_HIL, 32'h7FFF_FFFF);
      csr_write(lgm_pkg::CSR_LOWER, 32'h8000_0000);
      csr_write(lgm_pkg::CSR_UPPER, 32'h7FFF_FFFF);
      csr_write(lgm_pkg::CSR_MAXIT, 32'h0000_0000);
      add_search(3);
      drain();
      csr_write(lgm_pkg::CSR_MAXIT, 32'h0000_0FFF);
      csr_write(lgm_pkg::CSR_GOAL, 32'h0000_0000);
      add_search(5);
      drain();

      // target reached on first pop, goal reached at once
      csr_write(lgm_pkg::CSR_LIP, 32'h7FFF_FFFF);
      csr_write(lgm_pkg::CSR_HIL, 32'h0000_0000);
      csr_write(lgm_pkg::CSR_LOWER, 32'h7FFF_FFFF);
      csr_write(lgm_pkg::CSR_UPPER, 32'h8000_0000);
      csr_write(lgm_pkg::CSR_TGT, 32'h8000_0000);
      add_search(3);
      drain();
      csr_write(lgm_pkg::CSR_TGT, 32'h7FFF_FFFF);
      csr_write(lgm_pkg::CSR_GOAL, 32'h7FFF_FFFF);
      csr_write(lgm_pkg::CSR_MAXIT, 32'h0000_0001);
      add_search(3);
      drain();

      budget = 500;
      while (budget > 0) begin
         csr_write(lgm_pkg::CSR_LIP,
                   rand_reg(32'h1, 32'h7FFF_FFFF, $urandom_range(4096, 32'h0008_0000)));
         csr_write(lgm_pkg::CSR_HIL,
                   rand_reg(32'h0, 32'h7FFF_FFFF, $urandom_range(256, 32'h0002_0000)));
         csr_write(lgm_pkg::CSR_LOWER,
                   rand_reg(32'h8000_0000, 32'h7FFF_FFFF,
                            $urandom_range(0, 32'h0004_0000) - 32'h0002_0000));
         csr_write(lgm_pkg::CSR_UPPER,
                   rand_reg(32'h8000_0000, 32'h7FFF_FFFF,
                            $urandom_range(0, 32'h0004_0000) - 32'h0002_0000));
         csr_write(lgm_pkg::CSR_GOAL,
                   rand_reg(32'h0, 32'h7FFF_FFFF, $urandom_range(0, 4096)));
         csr_write(lgm_pkg::CSR_TGT,
                   rand_reg(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
         csr_write(lgm_pkg::CSR_MAXIT,
                   rand_reg(32'h0, 32'hFFF, $urandom_range(1, 40)));
         repeat (6) begin
            case ($urandom_range(0, 9))
               0: add_word(lgm_pkg::CMD_VALUE, $urandom());
               1: add_search($urandom_range(0, 3));
               default: add_search($urandom_range(5, 25));
            endcase
         end
         budget -= pending_words.size();
         drain();
      end

      $display("covered %0d words in %0d phases: %0d queries, %0d finished searches",
               n_words, n_phases, n_queries, n_done);
      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("%0d mismatches", errors);
         $display("status: fail");
      end
      $finish;
   end
endmodule

// File: files.f
sv/lgm_pkg.sv
sv/lgm_ctrl.sv
sv/lgm_dp.sv
sv/lipschitz_global_minimizer.sv
verif/tb_lipschitz_global_minimizer.sv
